/* hdl/bitmap_page_pool_allocator_assert.svh */
// Assertion macros for the bitmap page pool allocator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef BITMAP_PAGE_POOL_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPPA_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bppa_pkg.sv */
// Shared types, codes and constants of the bitmap page pool allocator.
// Used by bppa_engine, the top level, bppa_checker and the testbench; no dependencies.
package bppa_pkg;

    localparam int unsigned POOL_PAGES_DEF = 4096;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned CNT_W      = 12;
    localparam int unsigned PAGES_W    = 13;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned IDX_W      = ADDR_W - PAGE_SHIFT;
    localparam int unsigned CFG_IDX_W  = 3;

    // Bitmap memory word and scan lane geometry
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned WORD_SHIFT = 5;
    localparam int unsigned LANE_BITS  = 8;
    localparam int unsigned LANE_SHIFT = 3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] POOL_KV   = 2'd0;
    localparam logic [1:0] POOL_KP   = 2'd1;
    localparam logic [1:0] POOL_UP   = 2'd2;
    localparam logic [1:0] POOL_NONE = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KV_BASE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_BASE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_BASE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_PAGES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USER_PAGES   = 3'd4;

    localparam logic [ADDR_W-1:0]  KV_BASE_RST = 32'hC010_0000;
    localparam logic [ADDR_W-1:0]  KP_BASE_RST = 32'h0020_0000;
    localparam logic [ADDR_W-1:0]  UP_BASE_RST = 32'h0110_0000;
    localparam logic [PAGES_W-1:0] PAGES_RST   = 13'd3840;

    typedef struct packed {
        logic [ADDR_W-1:0]  kernel_virt_base;
        logic [ADDR_W-1:0]  kernel_phys_base;
        logic [ADDR_W-1:0]  user_phys_base;
        logic [PAGES_W-1:0] kernel_pages;
        logic [PAGES_W-1:0] user_pages;
    } cfg_t;

    typedef struct packed {
        logic              cmd;
        logic [1:0]        pool_select;
        logic [CNT_W-1:0]  page_count;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        logic [1:0]        status;
    } rsp_t;

endpackage

/* hdl/bppa_engine.sv */
// Request sequencer and bitmap memory of the page pool allocator.
// Depends on bppa_pkg and the assertion macros in bitmap_page_pool_allocator_assert.svh.
`include "bitmap_page_pool_allocator_assert.svh"

module bppa_engine
    import bppa_pkg::*;
#(
    parameter int unsigned POOL_PAGES = POOL_PAGES_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg_i,
    input  logic start_i,
    input  req_t req_i,
    output logic idle_o,
    output logic done_valid_o,
    input  logic done_ready_i,
    output rsp_t rsp_o
);

    localparam int unsigned NUM_WORDS = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned MEM_AW    = WORD_AW + 2;
    localparam int unsigned MEM_DEPTH = 1 << MEM_AW;
    localparam int unsigned PW        = (WORD_AW + 6 > 14) ? WORD_AW + 6 : 14;
    localparam int unsigned LANE_AW   = WORD_SHIFT - LANE_SHIFT;

    localparam logic [PW-1:0]         MAP_PAGES = PW'(POOL_PAGES);
    localparam logic [PW-1:0]         WORD_SPAN = PW'(WORD_BITS);
    localparam logic [PW-1:0]         LANE_SPAN = PW'(LANE_BITS);
    localparam logic [CNT_W:0]        WORD_RUN  = (CNT_W + 1)'(WORD_BITS);
    localparam logic [WORD_SHIFT-1:0] TOP_BIT   = WORD_SHIFT'(WORD_BITS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_OFFSET,
        S_BOUNDS,
        S_SCAN,
        S_UPD_RD,
        S_UPD_WR,
        S_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [MEM_AW-1:0]    clr_reg, clr_next;
    logic                 cmd_reg, cmd_next;
    logic [1:0]           pool_reg, pool_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [PW-1:0]        size_reg, size_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [WORD_AW-1:0]   word_reg, word_next;
    logic [LANE_AW-1:0]   lane_reg, lane_next;
    logic [CNT_W-1:0]     run_reg, run_next;
    logic [PW-1:0]        lo_reg, lo_next;
    logic [PW-1:0]        last_reg, last_next;
    logic                 set_reg, set_next;
    logic [1:0]           status_reg, status_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;

    logic [WORD_BITS-1:0] bitmap_mem [MEM_DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [MEM_AW-1:0]    rd_addr;
    logic                 wr_en;
    logic [MEM_AW-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Decode: effective pool, saturated pool size, pool base
    logic [1:0]           dec_pool;
    logic [PAGES_W-1:0]   dec_pages;
    logic [PW-1:0]        dec_size_full;
    logic [PW-1:0]        dec_size;
    logic [ADDR_W-1:0]    dec_base;
    logic [ADDR_W:0]      off_diff;
    logic                 bnd_over;

    // Scan
    logic [PW-1:0]        scan_wb;
    logic [PW-1:0]        scan_lane_base;
    logic                 scan_word_full;
    logic                 scan_word_end;
    logic                 scan_lane_end;
    logic                 scan_fast;
    logic                 scan_hit;
    logic [PW-1:0]        scan_hit_pg;
    logic [CNT_W-1:0]     scan_run;

    // Range update
    logic [WORD_AW-1:0]   upd_first_word;
    logic [WORD_AW-1:0]   upd_last_word;
    logic                 upd_last;
    logic [WORD_BITS-1:0] upd_mask;

    function automatic logic [1:0] req_sel_pool(
        input logic              cmd,
        input logic [1:0]        sel,
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] user_base
    );
        logic [1:0] pool;
        pool = sel;
        // A physical free picks its pool by address alone
        if (cmd == CMD_FREE && sel != POOL_KV && sel != POOL_NONE) begin
            pool = (addr >= user_base) ? POOL_UP : POOL_KP;
        end
        return pool;
    endfunction

    always_comb begin
        dec_pool = req_sel_pool(cmd_reg, pool_reg, addr_reg, cfg_i.user_phys_base);
        dec_pages = (dec_pool == POOL_UP) ? cfg_i.user_pages : cfg_i.kernel_pages;
        dec_size_full = PW'(dec_pages);
        dec_size = (dec_size_full > MAP_PAGES) ? MAP_PAGES : dec_size_full;
        case (dec_pool)
            POOL_KV: dec_base = cfg_i.kernel_virt_base;
            POOL_KP: dec_base = cfg_i.kernel_phys_base;
            default: dec_base = cfg_i.user_phys_base;
        endcase
    end

    assign off_diff = {1'b0, addr_reg} - {1'b0, base_reg};
    assign bnd_over = ((IDX_W + 1)'(idx_reg) + (IDX_W + 1)'(cnt_reg)) > (IDX_W + 1)'(size_reg);

    assign scan_wb        = PW'({word_reg, {WORD_SHIFT{1'b0}}});
    assign scan_lane_base = scan_wb + PW'({lane_reg, {LANE_SHIFT{1'b0}}});
    assign scan_word_full = (scan_wb + WORD_SPAN) <= size_reg;
    assign scan_word_end  = (scan_wb + WORD_SPAN) >= size_reg;
    assign scan_lane_end  = (scan_lane_base + LANE_SPAN) >= size_reg;
    assign scan_fast      = (lane_reg == '0) && scan_word_full &&
                            ((rd_data_reg == '1) ||
                             ((rd_data_reg == '0) && (({1'b0, run_reg} + WORD_RUN) <
                                                      {1'b0, cnt_reg})));

    // One 8-page lane of the first-fit run count
    always_comb begin : scan_lane
        logic [CNT_W-1:0]     r;
        logic                 hit;
        logic [PW-1:0]        hpg;
        logic [PW-1:0]        pg;
        logic [LANE_BITS-1:0] bits;
        r    = run_reg;
        hit  = 1'b0;
        hpg  = '0;
        bits = rd_data_reg[lane_reg * LANE_BITS +: LANE_BITS];
        for (int j = 0; j < LANE_BITS; j++) begin
            pg = scan_lane_base + PW'(j);
            if (!hit && pg < size_reg) begin
                if (bits[j]) begin
                    r = '0;
                end else begin
                    r = r + 1'b1;
                    if (r == cnt_reg) begin
                        hit = 1'b1;
                        hpg = pg;
                    end
                end
            end
        end
        scan_hit    = hit;
        scan_hit_pg = hpg;
        scan_run    = r;
    end

    assign upd_first_word = lo_reg[WORD_AW+WORD_SHIFT-1:WORD_SHIFT];
    assign upd_last_word  = last_reg[WORD_AW+WORD_SHIFT-1:WORD_SHIFT];
    assign upd_last       = (word_reg == upd_last_word);

    always_comb begin : upd_mask_gen
        logic [WORD_BITS-1:0] lo_m;
        logic [WORD_BITS-1:0] hi_m;
        lo_m = (word_reg == upd_first_word) ?
               ({WORD_BITS{1'b1}} << lo_reg[WORD_SHIFT-1:0]) : {WORD_BITS{1'b1}};
        hi_m = upd_last ?
               ({WORD_BITS{1'b1}} >> (TOP_BIT - last_reg[WORD_SHIFT-1:0])) :
               {WORD_BITS{1'b1}};
        upd_mask = lo_m & hi_m;
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cmd_next      = cmd_reg;
        pool_next     = pool_reg;
        cnt_next      = cnt_reg;
        addr_next     = addr_reg;
        size_next     = size_reg;
        base_next     = base_reg;
        idx_next      = idx_reg;
        word_next     = word_reg;
        lane_next     = lane_reg;
        run_next      = run_reg;
        lo_next       = lo_reg;
        last_next     = last_reg;
        set_next      = set_reg;
        status_next   = status_reg;
        res_addr_next = res_addr_reg;
        rd_addr       = {pool_reg, word_reg};
        wr_en         = 1'b0;
        wr_addr       = {pool_reg, word_reg};
        wr_data       = '0;

        case (state_reg)
            S_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start_i) begin
                    cmd_next   = req_i.cmd;
                    pool_next  = req_i.pool_select;
                    cnt_next   = req_i.page_count;
                    addr_next  = req_i.address;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                pool_next     = dec_pool;
                size_next     = dec_size;
                base_next     = dec_base;
                status_next   = ST_DONE;
                res_addr_next = '0;
                word_next     = '0;
                lane_next     = '0;
                run_next      = '0;
                // Prefetch word zero for the scan
                rd_addr       = {pool_reg, {WORD_AW{1'b0}}};
                if (pool_reg == POOL_NONE || cnt_reg == '0) begin
                    status_next = ST_BAD;
                    state_next  = S_RESP;
                end else if (cmd_reg == CMD_ALLOC) begin
                    state_next = S_SCAN;
                end else begin
                    state_next = S_OFFSET;
                end
            end
            S_OFFSET: begin
                idx_next = off_diff[ADDR_W-1:PAGE_SHIFT];
                if (addr_reg[PAGE_SHIFT-1:0] != '0 || off_diff[ADDR_W]) begin
                    status_next = ST_BAD;
                    state_next  = S_RESP;
                end else begin
                    state_next = S_BOUNDS;
                end
            end
            S_BOUNDS: begin
                lo_next   = PW'(idx_reg);
                last_next = PW'(idx_reg) + PW'(cnt_reg) - 1'b1;
                set_next  = 1'b0;
                if (bnd_over) begin
                    status_next = ST_BAD;
                    state_next  = S_RESP;
                end else begin
                    state_next = S_UPD_RD;
                end
            end
            S_SCAN: begin
                if (scan_fast) begin
                    run_next = (rd_data_reg == '1) ? '0 : run_reg + WORD_RUN[CNT_W-1:0];
                    if (scan_word_end) begin
                        status_next = ST_NOROOM;
                        state_next  = S_RESP;
                    end else begin
                        word_next = word_reg + 1'b1;
                    end
                end else if (scan_hit) begin
                    lo_next    = scan_hit_pg - PW'(cnt_reg) + 1'b1;
                    last_next  = scan_hit_pg;
                    set_next   = 1'b1;
                    state_next = S_UPD_RD;
                end else if (scan_lane_end) begin
                    status_next = ST_NOROOM;
                    state_next  = S_RESP;
                end else begin
                    run_next  = scan_run;
                    lane_next = lane_reg + 1'b1;
                    if (lane_reg == '1) begin
                        word_next = word_reg + 1'b1;
                    end
                end
                // Read the word that the next evaluation works on
                rd_addr = {pool_reg, word_next};
            end
            S_UPD_RD: begin
                word_next     = upd_first_word;
                rd_addr       = {pool_reg, upd_first_word};
                res_addr_next = set_reg ? base_reg + (ADDR_W'(lo_reg) << PAGE_SHIFT) : '0;
                state_next    = S_UPD_WR;
            end
            S_UPD_WR: begin
                wr_en   = 1'b1;
                wr_addr = {pool_reg, word_reg};
                wr_data = set_reg ? (rd_data_reg | upd_mask) : (rd_data_reg & ~upd_mask);
                rd_addr = {pool_reg, word_reg + 1'b1};
                if (upd_last) begin
                    status_next = ST_DONE;
                    state_next  = S_RESP;
                end else begin
                    word_next = word_reg + 1'b1;
                end
            end
            S_RESP: begin
                if (done_ready_i) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cmd_reg      <= cmd_next;
            pool_reg     <= pool_next;
            cnt_reg      <= cnt_next;
            addr_reg     <= addr_next;
            size_reg     <= size_next;
            base_reg     <= base_next;
            idx_reg      <= idx_next;
            word_reg     <= word_next;
            lane_reg     <= lane_next;
            run_reg      <= run_next;
            lo_reg       <= lo_next;
            last_reg     <= last_next;
            set_reg      <= set_next;
            status_reg   <= status_next;
            res_addr_reg <= res_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= bitmap_mem[rd_addr];
    end

    assign idle_o            = (state_reg == S_IDLE);
    assign done_valid_o      = (state_reg == S_RESP);
    assign rsp_o.page_address = res_addr_reg;
    assign rsp_o.status       = status_reg;

    `BPPA_ASSERT_IMPLIES(a_scan_run_below_count, aclk, aresetn, state_reg == S_SCAN, run_reg < cnt_reg, "scan run reached count without a hit")
    `BPPA_ASSERT_IMPLIES(a_update_range_in_pool, aclk, aresetn, state_reg == S_UPD_RD, (lo_reg <= last_reg) && (last_reg < size_reg), "update range outside the pool")
    `BPPA_ASSERT_IMPLIES(a_update_word_in_range, aclk, aresetn, state_reg == S_UPD_WR, (word_reg >= upd_first_word) && (word_reg <= upd_last_word), "update word outside the range")
    `BPPA_ASSERT_NEXT(a_update_word_advance, aclk, aresetn, (state_reg == S_UPD_WR) && !upd_last, (state_reg == S_UPD_WR) && (word_reg == $past(word_reg) + 1'b1), "update skipped a word")
    `BPPA_ASSERT_IMPLIES(a_failed_zero_addr, aclk, aresetn, (state_reg == S_RESP) && (status_reg != ST_DONE), res_addr_reg == '0, "failed request returns an address")

endmodule

/* hdl/bitmap_page_pool_allocator.sv */
// Bitmap page pool allocator, top level: configuration registers, handshakes, result register.
// Depends on bppa_pkg and bppa_engine.

// Three page pools (kernel virtual, kernel physical, user physical) are kept as bitmaps in one
// memory of 32-bit words, 4 * 2^ceil(log2(ceil(POOL_PAGES/32))) words deep (512 for 4096
// pages). After reset the block sweeps that memory to zero, one word per cycle, with s_ready
// low; configuration writes are taken at any time. An alloc is a first-fit scan through the
// single read port of that memory: a word that is fully used, or fully free and short of the
// requested run, is skipped whole; any other word is walked in 8-page lanes, one lane per
// cycle. The scan stops at the first fit. The run is then marked at one word per cycle after
// a setup step. A free passes the offset and bounds checks and then the same word-per-cycle
// update. Every request also passes through accept, decode and response steps; one
// transaction is worked on at a time, and the next is accepted while the last result still
// waits on m_valid.
module bitmap_page_pool_allocator
    import bppa_pkg::*;
#(
    parameter int unsigned POOL_PAGES = POOL_PAGES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [1:0]           s_pool_select,
    input  logic [CNT_W-1:0]     s_page_count,
    input  logic [ADDR_W-1:0]    s_address,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_page_address,
    output logic [1:0]           m_status
);

    cfg_t              cfg_reg;
    req_t              req;
    rsp_t              rsp;
    logic              eng_idle;
    logic              eng_done;
    logic              eng_done_ready;
    logic              m_valid_reg;
    logic [ADDR_W-1:0] m_page_address_reg;
    logic [1:0]        m_status_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = eng_idle;

    assign req.cmd         = s_cmd;
    assign req.pool_select = s_pool_select;
    assign req.page_count  = s_page_count;
    assign req.address     = s_address;

    // Hand over a result only when the output register is free or draining
    assign eng_done_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kernel_virt_base <= KV_BASE_RST;
            cfg_reg.kernel_phys_base <= KP_BASE_RST;
            cfg_reg.user_phys_base   <= UP_BASE_RST;
            cfg_reg.kernel_pages     <= PAGES_RST;
            cfg_reg.user_pages       <= PAGES_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_KV_BASE:      cfg_reg.kernel_virt_base <= cfg_data;
                REG_KP_BASE:      cfg_reg.kernel_phys_base <= cfg_data;
                REG_UP_BASE:      cfg_reg.user_phys_base   <= cfg_data;
                REG_KERNEL_PAGES: cfg_reg.kernel_pages     <= cfg_data[PAGES_W-1:0];
                REG_USER_PAGES:   cfg_reg.user_pages       <= cfg_data[PAGES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_done && eng_done_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_done && eng_done_ready) begin
            m_page_address_reg <= rsp.page_address;
            m_status_reg       <= rsp.status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_page_address = m_page_address_reg;
    assign m_status       = m_status_reg;

    bppa_engine #(
        .POOL_PAGES(POOL_PAGES)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_i        (cfg_reg),
        .start_i      (s_valid && s_ready),
        .req_i        (req),
        .idle_o       (eng_idle),
        .done_valid_o (eng_done),
        .done_ready_i (eng_done_ready),
        .rsp_o        (rsp)
    );

endmodule

/* dv/bppa_checker.sv */
// Scoreboard for the bitmap page pool allocator: tracks the three page bitmaps and the pool
// registers, predicts each response and compares it with the one on the result channel.
// Depends on bppa_pkg.
module bppa_checker
    import bppa_pkg::*;
#(
    parameter int unsigned POOL_PAGES = POOL_PAGES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [1:0]           s_pool_select,
    input  logic [CNT_W-1:0]     s_page_count,
    input  logic [ADDR_W-1:0]    s_address,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [ADDR_W-1:0]    m_page_address,
    input  logic [1:0]           m_status,
    output int unsigned          fail_count,
    output int unsigned          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t                pool_cfg;
    bit [POOL_PAGES-1:0] used_pages [3];
    rsp_t                owed_rsp [$];
    int unsigned         errors;
    rsp_t                want;
    req_t                req;

    function automatic int unsigned pool_span(logic [1:0] pool);
        int unsigned n;
        n = (pool == POOL_UP) ? pool_cfg.user_pages : pool_cfg.kernel_pages;
        return (n > POOL_PAGES) ? POOL_PAGES : n;
    endfunction

    function automatic logic [ADDR_W-1:0] pool_origin(logic [1:0] pool);
        case (pool)
            POOL_KV: return pool_cfg.kernel_virt_base;
            POOL_KP: return pool_cfg.kernel_phys_base;
            default: return pool_cfg.user_phys_base;
        endcase
    endfunction

    // First-fit alloc or range free; updates the bitmaps and returns the response.
    function automatic rsp_t alloc_or_free(req_t rq);
        rsp_t              res;
        logic [1:0]        pool;
        logic [ADDR_W-1:0] base;
        int unsigned       span, run, first, idx, i;
        bit                found;
        res.page_address = '0;
        res.status       = ST_DONE;
        if (rq.pool_select == POOL_NONE) begin
            res.status = ST_BAD;
        end else if (rq.cmd == CMD_ALLOC) begin
            span = pool_span(rq.pool_select);
            if (rq.page_count == 0) begin
                res.status = ST_BAD;
            end else begin
                run   = 0;
                first = 0;
                found = 1'b0;
                for (i = 0; i < span && !found; i++) begin
                    if (used_pages[rq.pool_select][i]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == rq.page_count) begin
                            first = i + 1 - run;
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    for (i = first; i < first + rq.page_count; i++)
                        used_pages[rq.pool_select][i] = 1'b1;
                    res.page_address = pool_origin(rq.pool_select) + (first << PAGE_SHIFT);
                end else begin
                    res.status = ST_NOROOM;
                end
            end
        end else begin
            // physical frees pick their pool from the address alone
            pool = rq.pool_select;
            if (pool != POOL_KV)
                pool = (rq.address >= pool_cfg.user_phys_base) ? POOL_UP : POOL_KP;
            base = pool_origin(pool);
            span = pool_span(pool);
            if (rq.page_count == 0 || rq.address[PAGE_SHIFT-1:0] != 0 || rq.address < base) begin
                res.status = ST_BAD;
            end else begin
                idx = (rq.address - base) >> PAGE_SHIFT;
                if (idx > span || rq.page_count > span - idx) begin
                    res.status = ST_BAD;
                end else begin
                    for (i = idx; i < idx + rq.page_count; i++)
                        used_pages[pool][i] = 1'b0;
                end
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            pool_cfg.kernel_virt_base = KV_BASE_RST;
            pool_cfg.kernel_phys_base = KP_BASE_RST;
            pool_cfg.user_phys_base   = UP_BASE_RST;
            pool_cfg.kernel_pages     = PAGES_RST;
            pool_cfg.user_pages       = PAGES_RST;
            for (int p = 0; p < 3; p++)
                used_pages[p] = '0;
            owed_rsp.delete();
            errors = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KV_BASE:      pool_cfg.kernel_virt_base = cfg_data;
                    REG_KP_BASE:      pool_cfg.kernel_phys_base = cfg_data;
                    REG_UP_BASE:      pool_cfg.user_phys_base   = cfg_data;
                    REG_KERNEL_PAGES: pool_cfg.kernel_pages     = cfg_data[PAGES_W-1:0];
                    REG_USER_PAGES:   pool_cfg.user_pages       = cfg_data[PAGES_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (owed_rsp.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected response: page_address %h status %0d",
                             $time, m_page_address, m_status);
                end else begin
                    want = owed_rsp.pop_front();
                    if (m_page_address !== want.page_address) begin
                        errors++;
                        $display("%0t: page_address mismatch: expected %h actual %h",
                                 $time, want.page_address, m_page_address);
                    end
                    if (m_status !== want.status) begin
                        errors++;
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, m_status);
                    end
                end
            end

            if (s_valid && s_ready) begin
                req.cmd         = s_cmd;
                req.pool_select = s_pool_select;
                req.page_count  = s_page_count;
                req.address     = s_address;
                owed_rsp.push_back(alloc_or_free(req));
            end
        end
        fail_count      <= errors;
        pending_results <= owed_rsp.size();
    end

endmodule

/* dv/testbench.sv */
// Top of the bitmap page pool allocator testbench: clock, reset, configuration phases and
// request/response traffic with random gaps; the verdict comes from bppa_checker.
// Depends on bppa_pkg, bppa_checker and bitmap_page_pool_allocator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bppa_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int unsigned DRAIN_CYCLES = 1000;
    localparam int unsigned PAGE_BYTES   = 4096;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_USER_PAGES + 3'd1;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [ADDR_W-1:0]    cfg_data       = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic                 s_cmd          = CMD_ALLOC;
    logic [1:0]           s_pool_select  = POOL_KV;
    logic [CNT_W-1:0]     s_page_count   = '0;
    logic [ADDR_W-1:0]    s_address      = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [ADDR_W-1:0]    m_page_address;
    logic [1:0]           m_status;

    int unsigned fail_count;
    int unsigned pending_results;
    int unsigned cycle_count = 0;
    logic        steady  = 1'b0;
    logic        gapless = 1'b0;

    // register values as last written, for aiming frees at real pages
    logic [ADDR_W-1:0]  kv_base      = KV_BASE_RST;
    logic [ADDR_W-1:0]  kp_base      = KP_BASE_RST;
    logic [ADDR_W-1:0]  up_base      = UP_BASE_RST;
    logic [PAGES_W-1:0] kernel_pages = PAGES_RST;
    logic [PAGES_W-1:0] user_pages   = PAGES_RST;

    bitmap_page_pool_allocator dut (.*);

    bppa_checker u_checker (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 33);
    end

    function automatic int unsigned span_of(logic [1:0] pool);
        int unsigned n;
        n = (pool == POOL_UP) ? user_pages : kernel_pages;
        return (n > POOL_PAGES_DEF) ? POOL_PAGES_DEF : n;
    endfunction

    function automatic logic [ADDR_W-1:0] base_of(logic [1:0] pool);
        case (pool)
            POOL_KV: return kv_base;
            POOL_KP: return kp_base;
            default: return up_base;
        endcase
    endfunction

    // Hold cfg_valid high across back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_KV_BASE:      kv_base      = data;
            REG_KP_BASE:      kp_base      = data;
            REG_UP_BASE:      up_base      = data;
            REG_KERNEL_PAGES: kernel_pages = data[PAGES_W-1:0];
            REG_USER_PAGES:   user_pages   = data[PAGES_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [ADDR_W-1:0] kvb, input logic [ADDR_W-1:0] kpb,
                             input logic [ADDR_W-1:0] upb, input logic [PAGES_W-1:0] kpg,
                             input logic [PAGES_W-1:0] upg);
        write_reg(REG_KV_BASE, kvb);
        write_reg(REG_KP_BASE, kpb);
        write_reg(REG_UP_BASE, upb);
        // junk above the 13-bit page counts must be dropped
        write_reg(REG_KERNEL_PAGES, {19'($urandom()), kpg});
        write_reg(REG_USER_PAGES, {19'($urandom()), upg});
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    task automatic issue(input logic cmd, input logic [1:0] sel, input logic [CNT_W-1:0] cnt,
                         input logic [ADDR_W-1:0] addr);
        while (!gapless && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_pool_select <= sel;
        s_page_count  <= cnt;
        s_address     <= addr;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic issue_random();
        logic [1:0]        sel;
        logic [1:0]        pool;
        logic [ADDR_W-1:0] addr;
        int unsigned       span, idx, cnt, pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            issue(1'($urandom_range(1)), 2'($urandom_range(3)), CNT_W'($urandom()), $urandom());
        end else if (pick < 50) begin
            sel  = 2'($urandom_range(2));
            span = span_of(sel);
            pick = $urandom_range(99);
            if (pick < 70)
                cnt = $urandom_range(8, 1);
            else if (pick < 90)
                cnt = $urandom_range(64, 1);
            else if (pick < 98)
                cnt = $urandom_range(span + 2, 1);
            else
                cnt = $urandom_range(4095);
            issue(CMD_ALLOC, sel, CNT_W'(cnt), $urandom());
        end else begin
            pool = 2'($urandom_range(2));
            sel  = (pool == POOL_KV) ? POOL_KV : ($urandom_range(1) ? POOL_KP : POOL_UP);
            span = span_of(pool);
            // favor the low pages, where first fit puts its runs
            idx  = ($urandom_range(1) && span > 128) ? $urandom_range(128) : $urandom_range(span);
            pick = $urandom_range(99);
            if (pick < 60)
                cnt = $urandom_range(8, 1);
            else if (pick < 80)
                cnt = $urandom_range(64, 1);
            else if (pick < 90)
                cnt = span - idx;
            else
                cnt = span - idx + 1;
            addr = base_of(pool) + (idx << PAGE_SHIFT);
            pick = $urandom_range(99);
            if (pick < 4)
                addr = addr + $urandom_range(PAGE_BYTES - 1, 1);
            else if (pick < 8)
                addr = base_of(pool) - ($urandom_range(4, 1) << PAGE_SHIFT);
            else if (pick < 11)
                cnt = 0;
            issue(CMD_FREE, sel, CNT_W'(cnt), addr);
        end
    endtask

    task automatic run_random(input int unsigned items, input int unsigned calm_lo,
                              input int unsigned calm_hi);
        int unsigned k;
        for (k = 0; k < items; k++) begin
            gapless = (k >= calm_lo && k < calm_hi);
            steady <= gapless;
            issue_random();
        end
        gapless = 1'b0;
        steady <= 1'b0;
    endtask

    initial begin
        int unsigned rep;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: corner requests
        issue(CMD_ALLOC, POOL_KV, 12'd1, '0);
        issue(CMD_ALLOC, POOL_KP, 12'd1, '1);
        issue(CMD_ALLOC, POOL_UP, 12'd1, '0);
        issue(CMD_ALLOC, POOL_KV, 12'd0, '0);
        issue(CMD_ALLOC, POOL_NONE, 12'd1, '0);
        issue(CMD_FREE, POOL_NONE, 12'd1, KP_BASE_RST);
        issue(CMD_ALLOC, POOL_KP, 12'd4095, '0);
        issue(CMD_ALLOC, POOL_UP, 12'd3839, '0);
        issue(CMD_ALLOC, POOL_UP, 12'd1, '0);
        issue(CMD_FREE, POOL_KP, 12'd3839, UP_BASE_RST + PAGE_BYTES);
        issue(CMD_ALLOC, POOL_UP, 12'd3840, '0);
        issue(CMD_FREE, POOL_UP, 12'd1, KP_BASE_RST);
        issue(CMD_FREE, POOL_KP, 12'd1, KP_BASE_RST);
        issue(CMD_FREE, POOL_KP, 12'd1, KP_BASE_RST + 32'h800);
        issue(CMD_FREE, POOL_KV, 12'd1, KV_BASE_RST - PAGE_BYTES);
        issue(CMD_FREE, POOL_KV, 12'd0, KV_BASE_RST);
        issue(CMD_FREE, POOL_KP, 12'd2, KP_BASE_RST + 3839 * PAGE_BYTES);
        issue(CMD_FREE, POOL_KP, 12'd1, KP_BASE_RST + 3839 * PAGE_BYTES);
        issue(CMD_FREE, POOL_KP, 12'd1, KP_BASE_RST + 3840 * PAGE_BYTES);
        issue(CMD_FREE, POOL_UP, 12'd1, 32'hFFFF_F000);
        issue(CMD_ALLOC, POOL_KV, 12'd3840, '0);
        issue(CMD_FREE, POOL_KV, 12'd1, KV_BASE_RST);
        issue(CMD_ALLOC, POOL_KV, 12'd3840, '0);
        issue(CMD_FREE, POOL_KV, 12'd4095, KV_BASE_RST);
        issue(CMD_FREE, POOL_KV, 12'd3840, KV_BASE_RST);

        run_random(250, 0, 0);

        // small pools: short scans, heavy churn, one long stretch without stalls
        drain_results();
        configure(32'h4000_0000, 32'h0000_1000, 32'h0008_0000, 13'd64, 13'd40);
        run_random(300, 100, 250);

        // empty kernel pools, oversized user pool at the top of the address space
        drain_results();
        configure(32'hFFFF_F000, 32'h0000_0000, 32'hFFFF_F000, 13'd0, 13'h1FFF);
        run_random(150, 0, 0);

        // unaligned kernel virtual base, one-page user pool
        drain_results();
        configure(32'h0000_0800, 32'h0000_0000, 32'h8000_0000, 13'd4096, 13'd1);
        run_random(200, 0, 0);

        for (rep = 0; rep < 3; rep++) begin
            drain_results();
            write_reg(REG_UNMAPPED + 3'($urandom_range(2)), $urandom());
            configure($urandom() & 32'hFFFF_F000, $urandom() & 32'hFFFF_F000,
                      $urandom() & 32'hFFFF_F000, 13'($urandom_range(300, 1)),
                      13'($urandom_range(300)));
            run_random(70, 0, 0);
        end

        // pool sizes just past and right at the bitmap size
        drain_results();
        configure(KV_BASE_RST, KP_BASE_RST, UP_BASE_RST, 13'd4097, 13'd4096);
        run_random(140, 0, 0);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* bitmap_page_pool_allocator.f */
+incdir+hdl
hdl/bppa_pkg.sv
hdl/bppa_engine.sv
hdl/bitmap_page_pool_allocator.sv
dv/bppa_checker.sv
dv/testbench.sv
